/* src/bggc_pkg.sv */
package bggc_pkg;

  localparam int CHARGE_NODES = 5;
  localparam int TEMP_NODES   = 4;

  localparam logic [15:0]        CHG_LO   = 16'd6554;
  localparam logic [15:0]        CHG_HI   = 16'd58982;
  localparam logic signed [15:0] TMP_LO   = -16'sd2560;
  localparam logic signed [15:0] TMP_HI   = 16'sd12800;
  localparam int                 CHG_SPAN = 52428;
  localparam int                 TMP_SPAN = 15360;

  // Floor reciprocals of the spans, scaled by 2^32.
  localparam int RECIP_W   = 20;
  localparam logic [RECIP_W-1:0] CHG_RECIP = RECIP_W'((64'd1 << 32) / CHG_SPAN);
  localparam logic [RECIP_W-1:0] TMP_RECIP = RECIP_W'((64'd1 << 32) / TMP_SPAN);

  localparam int P_W  = 19;
  localparam int CI_W = $clog2(CHARGE_NODES);
  localparam int CJ_W = $clog2(TEMP_NODES);

  localparam logic [15:0] GAIN_ONE = 16'd16384;
  localparam logic [23:0] OUT_MAX  = 24'hFFFFFF;

  // The grids are split into four banks by row and column parity, so the
  // four corners of any cell sit in four different banks.
  localparam int ROW_H   = (CHARGE_NODES + 1) / 2;
  localparam int COL_H   = (TEMP_NODES + 1) / 2;
  localparam int BANK_D  = ROW_H * COL_H;
  localparam int BA_W    = (BANK_D > 1) ? $clog2(BANK_D) : 1;

  localparam int MQ_DEPTH = 8;
  localparam int MQ_AW    = $clog2(MQ_DEPTH);
  localparam int OQ_DEPTH = 8;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);

  typedef struct packed {
    logic        is_write;
    logic        grid;
    logic [2:0]  row;
    logic [1:0]  col;
    logic [15:0] gain;
    logic [23:0] r0;
    logic [23:0] r1;
  } ctx_t;

  typedef struct packed {
    ctx_t            ctx;
    logic [CI_W-1:0] ci;
    logic [CJ_W-1:0] cj;
    logic [16:0]     ws;
    logic [16:0]     wt;
  } mid_item_t;

  typedef struct packed {
    logic [23:0] c0;
    logic [23:0] c1;
    logic        sat;
  } out_item_t;

  function automatic logic [BA_W-1:0] bank_addr(input logic [2:0] row, input logic [2:0] col);
    int a;
    a = int'(row >> 1) * COL_H + int'(col >> 1);
    return BA_W'(a);
  endfunction

endpackage

/* src/bggc_front.sv */
module bggc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic                func_i,
  input  logic [15:0]         charge_level_i,
  input  logic signed [15:0]  temperature_i,
  input  logic [23:0]         resist_first_i,
  input  logic [23:0]         resist_second_i,
  input  logic [2:0]          row_select_i,
  input  logic [1:0]          col_select_i,
  input  logic                grid_select_i,
  input  logic [15:0]         gain_word_i,
  input  logic                mid_pop_i,
  output logic                mid_push_o,
  output bggc_pkg::mid_item_t mid_item_o
);
  import bggc_pkg::*;

  localparam int CNT_W = $clog2(MQ_DEPTH + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             acc;
  logic [4:0]       v_q;

  ctx_t             ctx1_q, ctx2_q, ctx3_q, ctx4_q;
  logic [P_W-1:0]   ps1_q, pt1_q;
  logic [CI_W-1:0]  ci2_q, ci3_q, ci4_q;
  logic [CJ_W-1:0]  cj2_q, cj3_q, cj4_q;
  logic [15:0]      fs2_q, ft2_q, fs3_q, ft3_q;
  logic [16:0]      qs3_q, qt3_q, qs4_q, qt4_q;
  logic [17:0]      rs4_q, rt4_q;
  mid_item_t        item5_q;

  logic [15:0]            s_cl;
  logic signed [15:0]     t_cl;
  logic [15:0]            ds, dt;
  logic [CI_W-1:0]        ci_d;
  logic [CJ_W-1:0]        cj_d;
  logic [RECIP_W+15:0]    mul_s, mul_t;
  logic [32:0]            num_s, num_t, qsp_s, qsp_t;
  logic [16:0]            ws_d, wt_d;
  ctx_t                   ctx_in;

  assign acc  = push && !full;
  assign full = (cnt_q >= CNT_W'(MQ_DEPTH));
  assign cnt_d = cnt_q + CNT_W'(acc) - CNT_W'(mid_pop_i);

  always_comb begin
    s_cl = charge_level_i;
    if (s_cl < CHG_LO) s_cl = CHG_LO;
    if (s_cl > CHG_HI) s_cl = CHG_HI;
    t_cl = temperature_i;
    if (t_cl < TMP_LO) t_cl = TMP_LO;
    if (t_cl > TMP_HI) t_cl = TMP_HI;
    ds = s_cl - CHG_LO;
    dt = 16'(t_cl - TMP_LO);
    ctx_in.is_write = func_i;
    ctx_in.grid     = grid_select_i;
    ctx_in.row      = row_select_i;
    ctx_in.col      = col_select_i;
    ctx_in.gain     = gain_word_i;
    ctx_in.r0       = resist_first_i;
    ctx_in.r1       = resist_second_i;
  end

  // The cell is the number of inner nodes at or below the point.
  always_comb begin
    ci_d = '0;
    for (int k = 1; k <= CHARGE_NODES - 2; k++) begin
      if (ps1_q >= P_W'(k * CHG_SPAN)) ci_d = ci_d + CI_W'(1);
    end
    cj_d = '0;
    for (int k = 1; k <= TEMP_NODES - 2; k++) begin
      if (pt1_q >= P_W'(k * TMP_SPAN)) cj_d = cj_d + CJ_W'(1);
    end
  end

  always_comb begin
    mul_s = (RECIP_W+16)'(fs2_q) * (RECIP_W+16)'(CHG_RECIP);
    mul_t = (RECIP_W+16)'(ft2_q) * (RECIP_W+16)'(TMP_RECIP);
    num_s = {1'b0, fs3_q, 16'd0} + 33'(CHG_SPAN / 2);
    num_t = {1'b0, ft3_q, 16'd0} + 33'(TMP_SPAN / 2);
    qsp_s = 33'(qs3_q) * 33'(CHG_SPAN);
    qsp_t = 33'(qt3_q) * 33'(TMP_SPAN);
  end

  // The reciprocal estimate is low by at most two.
  always_comb begin
    ws_d = qs4_q;
    if (rs4_q >= 18'(2 * CHG_SPAN)) ws_d = qs4_q + 17'd2;
    else if (rs4_q >= 18'(CHG_SPAN)) ws_d = qs4_q + 17'd1;
    wt_d = qt4_q;
    if (rt4_q >= 18'(2 * TMP_SPAN)) wt_d = qt4_q + 17'd2;
    else if (rt4_q >= 18'(TMP_SPAN)) wt_d = qt4_q + 17'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      v_q   <= '0;
    end else begin
      cnt_q <= cnt_d;
      v_q   <= {v_q[3:0], acc};
    end
  end

  always_ff @(posedge clk_i) begin
    ctx1_q <= ctx_in;
    ps1_q  <= P_W'(ds) * P_W'(CHARGE_NODES - 1);
    pt1_q  <= P_W'(dt) * P_W'(TEMP_NODES - 1);

    ctx2_q <= ctx1_q;
    ci2_q  <= ci_d;
    cj2_q  <= cj_d;
    fs2_q  <= 16'(ps1_q - P_W'(ci_d) * P_W'(CHG_SPAN));
    ft2_q  <= 16'(pt1_q - P_W'(cj_d) * P_W'(TMP_SPAN));

    ctx3_q <= ctx2_q;
    ci3_q  <= ci2_q;
    cj3_q  <= cj2_q;
    fs3_q  <= fs2_q;
    ft3_q  <= ft2_q;
    qs3_q  <= mul_s[32:16];
    qt3_q  <= mul_t[32:16];

    ctx4_q <= ctx3_q;
    ci4_q  <= ci3_q;
    cj4_q  <= cj3_q;
    qs4_q  <= qs3_q;
    qt4_q  <= qt3_q;
    rs4_q  <= 18'(num_s - qsp_s);
    rt4_q  <= 18'(num_t - qsp_t);

    item5_q.ctx <= ctx4_q;
    item5_q.ci  <= ci4_q;
    item5_q.cj  <= cj4_q;
    item5_q.ws  <= ws_d;
    item5_q.wt  <= wt_d;
  end

  assign mid_push_o = v_q[4];
  assign mid_item_o = item5_q;

endmodule

/* src/bggc_mid_queue.sv */
module bggc_mid_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  bggc_pkg::mid_item_t item_i,
  input  logic                pop_i,
  output logic                valid_o,
  output bggc_pkg::mid_item_t item_o
);
  import bggc_pkg::*;

  mid_item_t        mem_q [MQ_DEPTH];
  logic [MQ_AW-1:0] wp_q, rp_q;
  logic [MQ_AW:0]   cnt_q;

  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + MQ_AW'(1);
      if (pop_i)  rp_q <= rp_q + MQ_AW'(1);
      cnt_q <= cnt_q + (MQ_AW+1)'(push_i) - (MQ_AW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= item_i;
  end

endmodule

/* src/bggc_back.sv */
module bggc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                mid_valid_i,
  input  bggc_pkg::mid_item_t mid_item_i,
  output logic                mid_pop_o,
  output logic                empty,
  input  logic                pop,
  output logic [23:0]         corrected_first_o,
  output logic [23:0]         corrected_second_o,
  output logic                saturated_o
);
  import bggc_pkg::*;

  localparam int CNT_W = $clog2(OQ_DEPTH + 1);

  logic [15:0] mem_a_q [4][BANK_D];
  logic [15:0] mem_b_q [4][BANK_D];
  logic        val_a_q [4][BANK_D];
  logic        val_b_q [4][BANK_D];

  logic [CNT_W-1:0] bcnt_q;
  logic [3:0]       v_q;
  logic             is_apply, we, out_acc;
  logic [1:0]       wbank;
  logic [BA_W-1:0]  waddr;
  logic [BA_W-1:0]  raddr [4];
  logic [32:0]      w_d [4];

  logic [15:0] rd_a_q [4], rd_b_q [4];
  logic        rv_a_q [4], rv_b_q [4];
  logic [1:0]  par_q;
  logic [32:0] w1_q [4];
  logic [23:0] r0_q [4], r1_q [4];
  logic [47:0] pa_q [4], pb_q [4];
  logic [15:0] ga_q, gb_q;
  logic [39:0] m0_q, m1_q;
  logic [48:0] sum_a, sum_b;
  logic [26:0] v0, v1;

  out_item_t        oq_q [OQ_DEPTH];
  out_item_t        res;
  logic [OQ_AW-1:0] owp_q, orp_q;
  logic [OQ_AW:0]   ocnt_q;

  assign is_apply  = !mid_item_i.ctx.is_write;
  assign mid_pop_o = mid_valid_i && (bcnt_q < CNT_W'(OQ_DEPTH));
  assign empty     = (ocnt_q == '0);
  assign out_acc   = pop && !empty;

  always_comb begin
    logic [2:0] ci3, cj3, rr, rc;
    logic [16:0] ns, nt;
    ci3   = 3'(mid_item_i.ci);
    cj3   = 3'(mid_item_i.cj);
    we    = mid_pop_o && mid_item_i.ctx.is_write
            && ({1'b0, mid_item_i.ctx.row} < 4'(CHARGE_NODES))
            && ({2'b0, mid_item_i.ctx.col} < 4'(TEMP_NODES));
    wbank = {mid_item_i.ctx.row[0], mid_item_i.ctx.col[0]};
    waddr = bank_addr(mid_item_i.ctx.row, {1'b0, mid_item_i.ctx.col});
    for (int k = 0; k < 4; k++) begin
      rr = (ci3[0] == k[1]) ? ci3 : ci3 + 3'd1;
      rc = (cj3[0] == k[0]) ? cj3 : cj3 + 3'd1;
      raddr[k] = bank_addr(rr, rc);
    end
    ns = 17'd65536 - mid_item_i.ws;
    nt = 17'd65536 - mid_item_i.wt;
    w_d[0] = 33'(34'(ns) * 34'(nt));
    w_d[1] = 33'(34'(ns) * 34'(mid_item_i.wt));
    w_d[2] = 33'(34'(mid_item_i.ws) * 34'(nt));
    w_d[3] = 33'(34'(mid_item_i.ws) * 34'(mid_item_i.wt));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) begin
        for (int a = 0; a < BANK_D; a++) begin
          val_a_q[k][a] <= 1'b0;
          val_b_q[k][a] <= 1'b0;
        end
      end
    end else if (we) begin
      if (mid_item_i.ctx.grid) val_b_q[wbank][waddr] <= 1'b1;
      else                     val_a_q[wbank][waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      if (mid_item_i.ctx.grid) mem_b_q[wbank][waddr] <= mid_item_i.ctx.gain;
      else                     mem_a_q[wbank][waddr] <= mid_item_i.ctx.gain;
    end
    for (int k = 0; k < 4; k++) begin
      rd_a_q[k] <= mem_a_q[k][raddr[k]];
      rd_b_q[k] <= mem_b_q[k][raddr[k]];
      rv_a_q[k] <= val_a_q[k][raddr[k]];
      rv_b_q[k] <= val_b_q[k][raddr[k]];
      w1_q[k]   <= w_d[k];
    end
    par_q   <= {mid_item_i.ci[0], mid_item_i.cj[0]};
    r0_q[0] <= mid_item_i.ctx.r0;
    r1_q[0] <= mid_item_i.ctx.r1;
    for (int k = 1; k < 4; k++) begin
      r0_q[k] <= r0_q[k-1];
      r1_q[k] <= r1_q[k-1];
    end
  end

  // Corner c is {row step, column step}; its bank is c xor the cell parity.
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 4; c++) begin
      pa_q[c] <= 48'(49'(w1_q[c]) * 49'(rv_a_q[2'(c) ^ par_q] ? rd_a_q[2'(c) ^ par_q]
                                                             : GAIN_ONE));
      pb_q[c] <= 48'(49'(w1_q[c]) * 49'(rv_b_q[2'(c) ^ par_q] ? rd_b_q[2'(c) ^ par_q]
                                                             : GAIN_ONE));
    end
    ga_q <= sum_a[47:32];
    gb_q <= sum_b[47:32];
    m0_q <= 40'(ga_q) * 40'(r0_q[2]);
    m1_q <= 40'(gb_q) * 40'(r1_q[2]);
  end

  always_comb begin
    sum_a = 49'(pa_q[0]) + 49'(pa_q[1]) + 49'(pa_q[2]) + 49'(pa_q[3]) + 49'h80000000;
    sum_b = 49'(pb_q[0]) + 49'(pb_q[1]) + 49'(pb_q[2]) + 49'(pb_q[3]) + 49'h80000000;
    v0 = 27'((41'(m0_q) + 41'd8192) >> 14);
    v1 = 27'((41'(m1_q) + 41'd8192) >> 14);
    res.c0  = (v0 > 27'(OUT_MAX)) ? OUT_MAX : v0[23:0];
    res.c1  = (v1 > 27'(OUT_MAX)) ? OUT_MAX : v1[23:0];
    res.sat = (v0 > 27'(OUT_MAX)) || (v1 > 27'(OUT_MAX));
  end

  // The credit count covers requests in the back pipeline and the result queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcnt_q <= '0;
      v_q    <= '0;
      owp_q  <= '0;
      orp_q  <= '0;
      ocnt_q <= '0;
    end else begin
      bcnt_q <= bcnt_q + CNT_W'(mid_pop_o && is_apply) - CNT_W'(out_acc);
      v_q    <= {v_q[2:0], mid_pop_o && is_apply};
      if (v_q[3]) owp_q <= owp_q + OQ_AW'(1);
      if (out_acc) orp_q <= orp_q + OQ_AW'(1);
      ocnt_q <= ocnt_q + (OQ_AW+1)'(v_q[3]) - (OQ_AW+1)'(out_acc);
    end
  end

  always_ff @(posedge clk_i) begin
    if (v_q[3]) oq_q[owp_q] <= res;
  end

  assign corrected_first_o  = oq_q[orp_q].c0;
  assign corrected_second_o = oq_q[orp_q].c1;
  assign saturated_o        = oq_q[orp_q].sat;

endmodule

/* src/bilinear_gain_grid_correction_top.sv */
// Bilinear gain-grid correction: takes one request per cycle while full is
// low, write or apply, and returns one result per apply request in order;
// write requests give none. The path is fully pipelined: five front stages
// (clamp, cell search, weight by reciprocal multiply and correction), an
// 8-entry queue, and four back stages (bank read, corner products, rounding
// sum, resistance multiply) whose saturated result is written into an
// 8-entry result queue. The grids live in four parity banks reset to 1.0
// by per-entry valid bits, with no clearing pass.
module bilinear_gain_grid_correction_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic               func_i,
  input  logic [15:0]        charge_level_i,
  input  logic signed [15:0] temperature_i,
  input  logic [23:0]        resist_first_i,
  input  logic [23:0]        resist_second_i,
  input  logic [2:0]         row_select_i,
  input  logic [1:0]         col_select_i,
  input  logic               grid_select_i,
  input  logic [15:0]        gain_word_i,
  output logic               empty,
  input  logic               pop,
  output logic [23:0]        corrected_first_o,
  output logic [23:0]        corrected_second_o,
  output logic               saturated_o
);
  import bggc_pkg::*;

  logic      f_push, m_pop, m_valid;
  mid_item_t f_item, m_item;

  bggc_front u_front (
    .clk_i, .rst_ni, .push, .full, .func_i, .charge_level_i, .temperature_i,
    .resist_first_i, .resist_second_i, .row_select_i, .col_select_i,
    .grid_select_i, .gain_word_i,
    .mid_pop_i  (m_pop),
    .mid_push_o (f_push),
    .mid_item_o (f_item)
  );

  bggc_mid_queue u_mq (
    .clk_i, .rst_ni,
    .push_i  (f_push),
    .item_i  (f_item),
    .pop_i   (m_pop),
    .valid_o (m_valid),
    .item_o  (m_item)
  );

  bggc_back u_back (
    .clk_i, .rst_ni,
    .mid_valid_i (m_valid),
    .mid_item_i  (m_item),
    .mid_pop_o   (m_pop),
    .empty, .pop, .corrected_first_o, .corrected_second_o, .saturated_o
  );

endmodule

/* src/bggc_checker.sv */
module bggc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               push,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic [23:0]        corrected_first_o,
  input logic [23:0]        corrected_second_o,
  input logic               saturated_o
);

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("result queue not empty in reset");

  a_ready_after_reset: assert property (@(posedge clk_i)
    rst_ni && !$past(rst_ni) |-> !full)
    else $error("full right after reset");

  a_sat_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && saturated_o |->
      (corrected_first_o == 24'hFFFFFF) || (corrected_second_o == 24'hFFFFFF))
    else $error("saturated flag without a clipped result");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(corrected_first_o)
      && $stable(corrected_second_o) && $stable(saturated_o))
    else $error("waiting result changed");

  a_no_push_when_full_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown(full))
    else $error("full is unknown");

endmodule

bind bilinear_gain_grid_correction_top bggc_checker u_bggc_checker (.*);

/* test/bilinear_gain_grid_correction_top_test.sv */
`timescale 1ns / 100ps

module bilinear_gain_grid_correction_top_test;
  import bggc_pkg::*;

  typedef struct {
    bit               func;
    bit [15:0]        chg;
    bit signed [15:0] tmp;
    bit [23:0]        r0;
    bit [23:0]        r1;
    bit [2:0]         row;
    bit [1:0]         col;
    bit               grid;
    bit [15:0]        gain;
  } request_t;

  typedef struct {
    bit [23:0] c0;
    bit [23:0] c1;
    bit        sat;
  } correction_t;

  typedef struct {
    request_t    req;
    bit          fixed;
    correction_t want;
  } dir_row_t;

  localparam int FUNC_APPLY = 0;
  localparam int FUNC_WRITE = 1;
  localparam int GRID_A     = 0;
  localparam int GRID_B     = 1;
  localparam int RAND_ITEMS = 1600;
  localparam int DIR_ITEMS  = 14;

  logic               clk_i;
  logic               rst_ni;
  logic               push;
  logic               full;
  logic               func_i;
  logic [15:0]        charge_level_i;
  logic signed [15:0] temperature_i;
  logic [23:0]        resist_first_i;
  logic [23:0]        resist_second_i;
  logic [2:0]         row_select_i;
  logic [1:0]         col_select_i;
  logic               grid_select_i;
  logic [15:0]        gain_word_i;
  logic               empty;
  logic               pop;
  logic [23:0]        corrected_first_o;
  logic [23:0]        corrected_second_o;
  logic               saturated_o;

  bilinear_gain_grid_correction_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .func_i             (func_i),
    .charge_level_i     (charge_level_i),
    .temperature_i      (temperature_i),
    .resist_first_i     (resist_first_i),
    .resist_second_i    (resist_second_i),
    .row_select_i       (row_select_i),
    .col_select_i       (col_select_i),
    .grid_select_i      (grid_select_i),
    .gain_word_i        (gain_word_i),
    .empty              (empty),
    .pop                (pop),
    .corrected_first_o  (corrected_first_o),
    .corrected_second_o (corrected_second_o),
    .saturated_o        (saturated_o)
  );

  bit [15:0]   gains_a[CHARGE_NODES*TEMP_NODES];
  bit [15:0]   gains_b[CHARGE_NODES*TEMP_NODES];
  correction_t pending_q[$];
  int          mismatches;
  int          hold_cycles;
  bit          hold_req;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

  // Finds the cell along one axis and the Q1.16 weight toward its upper node.
  function automatic void locate(input int x, input int lo, input int hi, input int nodes,
                                 output int cell_idx, output longint w);
    int span, p, f;
    span = hi - lo;
    p    = (x - lo) * (nodes - 1);
    cell_idx = p / span;
    if (cell_idx > nodes - 2) cell_idx = nodes - 2;
    f = p - cell_idx * span;
    w = ((longint'(f) << 16) + span / 2) / span;
  endfunction

  function automatic longint blend(input bit [15:0] g00, input bit [15:0] g10,
                                   input bit [15:0] g01, input bit [15:0] g11,
                                   input longint ws, input longint wt);
    longint unsigned acc;
    acc = longint'(65536 - ws) * (65536 - wt) * g00 + ws * (65536 - wt) * g10 +
          longint'(65536 - ws) * wt * g01 + ws * wt * g11;
    return longint'((acc + 64'h8000_0000) >> 32);
  endfunction

  function automatic bit [23:0] scale(input longint gain, input bit [23:0] r,
                                      inout bit sat);
    longint v;
    v = (gain * r + 8192) >>> 14;
    if (v > longint'(OUT_MAX)) begin
      sat = 1'b1;
      return OUT_MAX;
    end
    return v[23:0];
  endfunction

  // Updates the gain grids for a write and returns 1 with the correction for an apply.
  function automatic bit correct(input request_t r, output correction_t res);
    int     s, t, ci, cj, b;
    longint ws, wt, ka, kb;
    bit     sat;
    res = '{default: 0};
    if (r.func == FUNC_WRITE) begin
      if (r.row < CHARGE_NODES && r.col < TEMP_NODES) begin
        b = r.row * TEMP_NODES + r.col;
        if (r.grid == GRID_B) gains_b[b] = r.gain;
        else gains_a[b] = r.gain;
      end
      return 1'b0;
    end
    s = int'(r.chg);
    t = int'(r.tmp);
    if (s < int'(CHG_LO)) s = int'(CHG_LO);
    if (s > int'(CHG_HI)) s = int'(CHG_HI);
    if (t < int'(TMP_LO)) t = int'(TMP_LO);
    if (t > int'(TMP_HI)) t = int'(TMP_HI);
    locate(s, int'(CHG_LO), int'(CHG_HI), CHARGE_NODES, ci, ws);
    locate(t, int'(TMP_LO), int'(TMP_HI), TEMP_NODES, cj, wt);
    b  = ci * TEMP_NODES + cj;
    ka = blend(gains_a[b], gains_a[b+TEMP_NODES], gains_a[b+1], gains_a[b+TEMP_NODES+1],
               ws, wt);
    kb = blend(gains_b[b], gains_b[b+TEMP_NODES], gains_b[b+1], gains_b[b+TEMP_NODES+1],
               ws, wt);
    sat    = 1'b0;
    res.c0 = scale(ka, r.r0, sat);
    res.c1 = scale(kb, r.r1, sat);
    res.sat = sat;
    return 1'b1;
  endfunction

  task automatic offer(input request_t r, input bit fixed, input correction_t want);
    correction_t res;
    func_i          <= r.func;
    charge_level_i  <= r.chg;
    temperature_i   <= r.tmp;
    resist_first_i  <= r.r0;
    resist_second_i <= r.r1;
    row_select_i    <= r.row;
    col_select_i    <= r.col;
    grid_select_i   <= r.grid;
    gain_word_i     <= r.gain;
    push            <= 1'b1;
    do @(posedge clk_i); while (full);
    if (correct(r, res)) pending_q.push_back(fixed ? want : res);
  endtask

  function automatic bit [15:0] pick_charge();
    case ($urandom_range(0, 5))
      0: return 16'(int'(CHG_LO) + 13107 * $urandom_range(0, 4));
      1: return 16'($urandom_range(0, 6554));
      2: return 16'($urandom_range(58982, 65535));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic bit [15:0] pick_temp();
    case ($urandom_range(0, 5))
      0: return 16'(int'(TMP_LO) + 5120 * $urandom_range(0, 3));
      1: return 16'($urandom);
      2: return 16'(-2560 - $urandom_range(0, 30208));
      default: return 16'(-2560 + $urandom_range(0, 15360));
    endcase
  endfunction

  function automatic request_t pick_request();
    request_t r;
    r.func = ($urandom_range(0, 99) < 20) ? FUNC_WRITE : FUNC_APPLY;
    r.chg  = pick_charge();
    r.tmp  = pick_temp();
    r.r0   = ($urandom_range(0, 3) == 0) ? 24'($urandom_range(0, 4095)) : 24'($urandom);
    r.r1   = ($urandom_range(0, 3) == 0) ? 24'($urandom_range(0, 4095)) : 24'($urandom);
    r.row  = ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'($urandom_range(0, 4));
    r.col  = 2'($urandom);
    r.grid = 1'($urandom);
    r.gain = ($urandom_range(0, 2) == 0) ? 16'($urandom)
                                         : 16'(16384 - 4096 + $urandom_range(0, 8192));
    return r;
  endfunction

  // Result side: compares each popped result with the oldest expectation.
  initial begin
    correction_t want;
    int          cyc;
    int          pct;
    pop         <= 1'b0;
    hold_cycles = 0;
    cyc         = 0;
    pct         = 100;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h %h %b", corrected_first_o,
                                         corrected_second_o, saturated_o);
        end else begin
          want = pending_q.pop_front();
          if (want.c0 !== corrected_first_o || want.c1 !== corrected_second_o ||
              want.sat !== saturated_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %h %h %b, got %h %h %b", want.c0, want.c1,
                       want.sat, corrected_first_o, corrected_second_o, saturated_o);
          end
        end
      end
      cyc++;
      if (cyc % 400 == 0) begin
        case ($urandom_range(0, 3))
          0: pct = 100;
          1: pct = 70;
          2: pct = 30;
          default: pct = 8;
        endcase
      end
      if (hold_req) begin
        hold_req    = 1'b0;
        hold_cycles = 300;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  initial begin
    dir_row_t    dir_tab[DIR_ITEMS];
    correction_t none;
    int          burst;
    int          wait_cnt;

    for (int i = 0; i < CHARGE_NODES * TEMP_NODES; i++) begin
      gains_a[i] = GAIN_ONE;
      gains_b[i] = GAIN_ONE;
    end
    mismatches = 0;
    hold_req   = 1'b0;
    none       = '{default: 0};

    // After reset every gain is 1.0, so the first applies return their resistances.
    dir_tab[0]  = '{'{FUNC_APPLY, 16'h0000, 16'sh8000, 24'h0, 24'h0, 0, 0, 0, 0},
                    1, '{24'h0, 24'h0, 0}};
    dir_tab[1]  = '{'{FUNC_APPLY, 16'hFFFF, 16'sh7FFF, 24'hFFFFFF, 24'hFFFFFF, 7, 3, 1,
                      16'hFFFF}, 1, '{24'hFFFFFF, 24'hFFFFFF, 0}};
    dir_tab[2]  = '{'{FUNC_APPLY, CHG_LO, TMP_LO, 24'd1234, 24'd5678, 0, 0, 0, 0},
                    1, '{24'd1234, 24'd5678, 0}};
    dir_tab[3]  = '{'{FUNC_APPLY, CHG_HI, TMP_HI, 24'hABCDEF, 24'h123456, 0, 0, 0, 0},
                    1, '{24'hABCDEF, 24'h123456, 0}};
    dir_tab[4]  = '{'{FUNC_APPLY, 16'h8000, 16'sh0000, 24'hAAAAAA, 24'h555555, 0, 0, 0, 0},
                    1, '{24'hAAAAAA, 24'h555555, 0}};
    dir_tab[5]  = '{'{FUNC_WRITE, 0, 0, 0, 0, 0, 0, GRID_A, 16'hFFFF}, 0, none};
    dir_tab[6]  = '{'{FUNC_WRITE, 0, 0, 0, 0, 4, 3, GRID_B, 16'h0000}, 0, none};
    // Writes to a charge node that does not exist are dropped.
    dir_tab[7]  = '{'{FUNC_WRITE, 0, 0, 0, 0, 5, 0, GRID_A, 16'h0000}, 0, none};
    dir_tab[8]  = '{'{FUNC_WRITE, 0, 0, 0, 0, 7, 3, GRID_B, 16'h0000}, 0, none};
    dir_tab[9]  = '{'{FUNC_APPLY, 16'h0000, 16'sh8000, 24'hFFFFFF, 24'd1, 0, 0, 0, 0},
                    0, none};
    dir_tab[10] = '{'{FUNC_APPLY, 16'hFFFF, 16'sh7FFF, 24'd1, 24'hFFFFFF, 0, 0, 0, 0},
                    0, none};
    dir_tab[11] = '{'{FUNC_WRITE, 0, 0, 0, 0, 2, 1, GRID_A, 16'h8000}, 0, none};
    dir_tab[12] = '{'{FUNC_APPLY, 16'd32768, 16'sd1280, 24'h800000, 24'h7FFFFF, 0, 0, 0, 0},
                    0, none};
    dir_tab[13] = '{'{FUNC_APPLY, 16'd30000, 16'sd6000, 24'hFFFFFF, 24'hFFFFFF, 0, 0, 0, 0},
                    0, none};

    rst_ni          <= 1'b0;
    push            <= 1'b0;
    func_i          <= 1'b0;
    charge_level_i  <= '0;
    temperature_i   <= '0;
    resist_first_i  <= '0;
    resist_second_i <= '0;
    row_select_i    <= '0;
    col_select_i    <= '0;
    grid_select_i   <= 1'b0;
    gain_word_i     <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) offer(dir_tab[i].req, dir_tab[i].fixed, dir_tab[i].want);

    burst = $urandom_range(1, 20);
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == 600) hold_req = 1'b1;
      if (n == 1100) begin
        push <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk_i);
        repeat (20) @(posedge clk_i);
      end
      offer(pick_request(), 0, none);
      if (--burst == 0) begin
        burst = $urandom_range(1, 30);
        if ($urandom_range(0, 2) != 0) begin
          push <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk_i);
        end
      end
    end
    push <= 1'b0;

    wait_cnt = 0;
    while (pending_q.size() != 0 && wait_cnt < 100000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
